[design/markup_text_word_tokenizer_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the markup text word tokenizer
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MARKUP_TEXT_WORD_TOKENIZER_CORE_ASSERT_SVH
`define MARKUP_TEXT_WORD_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define MTTOK_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define MTTOK_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/mttok_pkg.sv]
// ---------------------------------------------------------------------------
// Markup text word tokenizer package
// Shared constants, character classes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mttok_pkg;

  localparam int MAX_WORD_CHARS = 63;
  localparam int IDX_W          = $clog2(MAX_WORD_CHARS);
  localparam int LEN_W          = $clog2(MAX_WORD_CHARS + 1);
  localparam int CHAR_W         = 8;
  localparam int POS_W          = 6;
  localparam int DOC_W          = 15;
  localparam int OUT_DATA_W     = 32;

  localparam logic [CHAR_W-1:0] CH_LT   = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_AMP  = 8'h26;
  localparam logic [CHAR_W-1:0] CH_GT   = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_USCR = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_B    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_M    = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_N    = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_P    = 8'h70;
  localparam logic [CHAR_W-1:0] CH_S    = 8'h73;

  typedef struct packed {
    logic accept;
    logic issue;
  } mttok_cmd_t;

  typedef struct packed {
    logic emit_go;
    logic issue_done;
    logic out_free;
  } mttok_stat_t;

  function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_USCR) ||
           (c == 8'hAA) || (c == 8'hB2) || (c == 8'hB3) || (c == 8'hB5) ||
           (c == 8'hB9) || (c == 8'hBA) || (c >= 8'hBC && c <= 8'hBE) ||
           (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
  endfunction

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    logic up;
    up = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7);
    return up ? c + 8'h20 : c;
  endfunction

endpackage

[design/mttok_datapath.sv]
// ---------------------------------------------------------------------------
// Markup text word tokenizer datapath
// Character classification, word buffer memory, emission counter and
// output register.
// ---------------------------------------------------------------------------
module mttok_datapath
  import mttok_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CHAR_W-1:0]     in_char,
  input  logic                  in_last,
  input  logic                  cfg_wr_en,
  input  logic [DOC_W-1:0]      cfg_wr_data,
  input  mttok_cmd_t            cmd,
  output mttok_stat_t           stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [CHAR_W-1:0] mem [MAX_WORD_CHARS];

  logic [DOC_W-1:0]  doc_r;
  logic              in_markup_r;
  logic [LEN_W-1:0]  wlen_r;
  logic [CHAR_W-1:0] pre_r   [4];
  logic [CHAR_W-1:0] pre_nxt [4];
  logic [LEN_W-1:0]  emit_len_r;
  logic [LEN_W-1:0]  rd_idx_r;
  logic [CHAR_W-1:0] rd_data_r;
  logic [POS_W-1:0]  pos_r;
  logic              last_r;
  logic              out_valid_r;

  logic              is_open;
  logic              is_close;
  logic              append;
  logic              flush;
  logic              stop;
  logic [CHAR_W-1:0] lc;
  logic [LEN_W-1:0]  flush_len;

  always_comb begin
    is_open   = (in_char == CH_LT) || (in_char == CH_AMP);
    is_close  = (in_char == CH_GT) || (in_char == CH_SEMI);
    lc        = to_lower(in_char);
    append    = !is_open && !in_markup_r && is_word_char(in_char) &&
                (wlen_r < LEN_W'(MAX_WORD_CHARS));
    flush     = is_open || (!in_markup_r && !append) || in_last;
    flush_len = append ? wlen_r + LEN_W'(1) : wlen_r;
    for (int k = 0; k < 4; k++) begin
      pre_nxt[k] = (append && wlen_r == LEN_W'(k)) ? lc : pre_r[k];
    end
    stop = (flush_len == LEN_W'(3) && pre_nxt[0] == CH_A && pre_nxt[1] == CH_M &&
            pre_nxt[2] == CH_P) ||
           (flush_len == LEN_W'(4) && pre_nxt[0] == CH_N && pre_nxt[1] == CH_B &&
            pre_nxt[2] == CH_S && pre_nxt[3] == CH_P);
    stat.emit_go    = flush && (flush_len > LEN_W'(1)) && !stop;
    stat.issue_done = (rd_idx_r == emit_len_r);
    stat.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && append) begin
      mem[wlen_r[IDX_W-1:0]] <= lc;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
      pos_r     <= POS_W'(rd_idx_r);
      last_r    <= (rd_idx_r + LEN_W'(1) == emit_len_r);
    end
    if (cmd.accept) begin
      for (int k = 0; k < 4; k++) begin
        pre_r[k] <= pre_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      doc_r       <= '0;
      in_markup_r <= 1'b0;
      wlen_r      <= '0;
      emit_len_r  <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        doc_r <= cfg_wr_data;
      end
      if (cmd.accept) begin
        wlen_r <= flush ? '0 : flush_len;
        if (in_last) begin
          in_markup_r <= 1'b0;
        end else if (is_open) begin
          in_markup_r <= 1'b1;
        end else if (in_markup_r && is_close) begin
          in_markup_r <= 1'b0;
        end
        if (stat.emit_go) begin
          emit_len_r <= flush_len;
          rd_idx_r   <= '0;
        end
      end else if (cmd.issue) begin
        rd_idx_r <= rd_idx_r + LEN_W'(1);
      end
      if (stat.out_free) begin
        out_valid_r <= cmd.issue;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_DATA_W - DOC_W - POS_W - CHAR_W){1'b0}}, doc_r, pos_r,
                       rd_data_r};

endmodule

[design/mttok_ctrl.sv]
// ---------------------------------------------------------------------------
// Markup text word tokenizer controller
// Alternates between taking characters and streaming out a finished word.
// ---------------------------------------------------------------------------
module mttok_ctrl
  import mttok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  mttok_stat_t stat,
  output mttok_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_tready_r;

  always_comb begin
    cmd.accept = in_tvalid && in_tready_r;
    cmd.issue  = (state_r == ST_EMIT) && !stat.issue_done && stat.out_free;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && stat.emit_go) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.issue_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

[design/markup_text_word_tokenizer_core.sv]
// ---------------------------------------------------------------------------
// Markup text word tokenizer core
// Takes one Latin-1 character per transaction and streams out the index
// words of a markup document, one lowercased character per transaction,
// each tagged with its position, a last-character flag and the document
// number. While no word is being emitted a character is taken every cycle;
// when a character ends a qualifying word, the input is held off while the
// word is read out of the word buffer memory, one character per cycle
// through its single read port unless the output applies back-pressure,
// which holds the input off for longer. The buffer needs no clearing after
// reset.
// ---------------------------------------------------------------------------
module markup_text_word_tokenizer_core
  import mttok_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] text_char
  input  logic                  in_tlast,   // end_of_text
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] word_char, [13:8] char_position,
                                            // [28:14] word_document, [31:29] zero
  output logic                  out_tlast,  // word_last
  input  logic                  cfg_wr_en,
  input  logic [DOC_W-1:0]      cfg_wr_data
);

  mttok_cmd_t  cmd;
  mttok_stat_t stat;

  mttok_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mttok_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_char     (in_tdata),
    .in_last     (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

[design/mttok_checker.sv]
// ---------------------------------------------------------------------------
// Markup text word tokenizer port checker
// Watches the top-level ports and checks word framing over time.
// ---------------------------------------------------------------------------
`include "markup_text_word_tokenizer_core_assert.svh"

module mttok_checker
  import mttok_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  logic [POS_W-1:0] exp_pos_r;
  logic             out_acc;

  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_pos_r <= '0;
    end else if (out_acc) begin
      exp_pos_r <= out_tlast ? '0 : exp_pos_r + POS_W'(1);
    end
  end

  `MTTOK_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")
  `MTTOK_ASSERT_IMP(a_pos_seq, out_tvalid, out_tdata[13:8] == exp_pos_r,
    "character position out of sequence")
  `MTTOK_ASSERT_IMP(a_word_len, out_tvalid && out_tlast, out_tdata[13:8] != 6'd0,
    "single-character word emitted")
  `MTTOK_ASSERT_IMP(a_in_hold, out_tvalid && !out_tlast, !in_tready,
    "input taken in the middle of a word")

endmodule

bind markup_text_word_tokenizer_core mttok_checker u_mttok_checker (.*);
